/* rtl/core/bdws_pkg.sv */
`default_nettype none

package bdws_pkg;

  // Payload widths fixed by the transaction format
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ACT_W        = 3;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CAPACITY_DEF = 64;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Sequencer to scan unit control
  typedef struct packed {
    logic start;      // clear accumulators, latch key
    logic search_en;  // this transaction is a search
    logic dvalid;     // read data from the ring is live this cycle
  } scan_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/bdws_if.sv */
`default_nettype none

// Request channel: action and operand
interface bdws_req_if;
  logic                              valid;
  logic                              ready;
  logic [bdws_pkg::ACT_W-1:0]        action;
  logic signed [bdws_pkg::DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// Response channel: status, hit, occupancy and maximum
interface bdws_rsp_if #(
  parameter int unsigned CNT_W = 7
);
  logic                               valid;
  logic                               ready;
  logic [bdws_pkg::STAT_W-1:0]        status;
  logic                               found;
  logic [CNT_W-1:0]                   count;
  logic signed [bdws_pkg::DATA_W-1:0] max_value;

  modport source (output valid, output status, output found, output count,
                  output max_value, input ready);
  modport sink   (input valid, input status, input found, input count,
                  input max_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/bdws_ring.sv */
`default_nettype none

// Ring storage: one write port, one registered read port
module bdws_ring #(
  parameter int unsigned DEPTH = bdws_pkg::CAPACITY_DEF,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [IW-1:0]               waddr_i,
  input  wire logic [bdws_pkg::DATA_W-1:0] wdata_i,
  input  wire logic [IW-1:0]               raddr_i,
  output logic      [bdws_pkg::DATA_W-1:0] rdata_o
);

  logic [bdws_pkg::DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered: data appears in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/bdws_scan.sv */
`default_nettype none

// Shared compare unit: running signed maximum and equality hit
module bdws_scan (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bdws_pkg::scan_ctrl_t               ctrl_i,
  input  wire logic signed [bdws_pkg::DATA_W-1:0] key_i,
  input  wire logic signed [bdws_pkg::DATA_W-1:0] data_i,
  output logic signed      [bdws_pkg::DATA_W-1:0] max_o,
  output logic                                    found_o
);

  logic                               have_q, have_d;
  logic                               found_q, found_d;
  logic                               srch_q, srch_d;
  logic signed [bdws_pkg::DATA_W-1:0] max_q, max_d;
  logic signed [bdws_pkg::DATA_W-1:0] key_q, key_d;
  logic                               gt;
  logic                               hit;

  // one comparator pair serves every element in turn
  assign gt  = data_i > max_q;
  assign hit = data_i == key_q;

  always_comb begin
    have_d  = have_q;
    found_d = found_q;
    srch_d  = srch_q;
    max_d   = max_q;
    key_d   = key_q;
    if (ctrl_i.start) begin
      have_d  = 1'b0;
      found_d = 1'b0;
      srch_d  = ctrl_i.search_en;
      max_d   = '0;
      key_d   = key_i;
    end else if (ctrl_i.dvalid) begin
      have_d = 1'b1;
      if (!have_q || gt) begin
        max_d = data_i;
      end
      if (srch_q && hit) begin
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      found_q <= 1'b0;
      srch_q  <= 1'b0;
    end else begin
      have_q  <= have_d;
      found_q <= found_d;
      srch_q  <= srch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    key_q <= key_d;
  end

  assign max_o   = max_q;
  assign found_o = found_q;

endmodule

`default_nettype wire

/* rtl/core/bounded_deque_with_search.sv */
`default_nettype none

// Bounded double-ended queue of signed 32-bit values with a membership search.
// Each request transaction pushes at the front or back, removes the front or
// back, or searches for a value; each returns one response with status, hit
// flag, element count and the largest stored value (0 when empty). After a
// request is taken, the sequencer walks the live elements front to back
// through the single read port of the ring store, one element per cycle, and
// one shared comparator pair folds in the maximum and the search hit. A
// request then passes through the scan, drain and done states (straight to
// done when the queue ends up empty), and the response is registered in the
// done state. The request side is ready again once the response is
// registered, even if that response has not yet been taken; a response left
// waiting holds the next request back. The store needs no clearing after reset.
// The response interface must be built with CNT_W = $clog2(CAPACITY + 1).
module bounded_deque_with_search #(
  parameter int unsigned CAPACITY = bdws_pkg::CAPACITY_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bdws_req_if.sink   req_i,
  bdws_rsp_if.source rsp_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [IW-1:0]                 front_q, front_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [IW-1:0]                 rd_ptr_q, rd_ptr_d;
  logic [IW-1:0]                 idx_q, idx_d;
  logic                          rd_vld_q;
  logic [bdws_pkg::STAT_W-1:0]   stat_q, stat_d;

  logic                          accept;
  logic                          full;
  logic                          empty;
  logic [IW-1:0]                 front_dec;
  logic [IW-1:0]                 front_inc;
  logic [IW:0]                   back_sum;
  logic [IW-1:0]                 back_addr;
  logic                          we;
  logic [IW-1:0]                 waddr;
  logic [bdws_pkg::DATA_W-1:0]   rdata;
  logic                          last_issue;
  logic                          rsp_free;

  logic                               rsp_vld_q;
  logic [bdws_pkg::STAT_W-1:0]        rsp_stat_q;
  logic                               rsp_found_q;
  logic [CW-1:0]                      rsp_cnt_q;
  logic signed [bdws_pkg::DATA_W-1:0] rsp_max_q;

  bdws_pkg::scan_ctrl_t               scan_ctrl;
  logic signed [bdws_pkg::DATA_W-1:0] scan_max;
  logic                               scan_found;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (cnt_q == CW'(CAPACITY));
  assign empty       = (cnt_q == '0);
  assign rsp_free    = !rsp_vld_q || rsp_o.ready;

  // ring index arithmetic
  assign front_dec = (front_q == '0) ? IW'(CAPACITY - 1) : front_q - IW'(1);
  assign front_inc = (front_q == IW'(CAPACITY - 1)) ? '0 : front_q + IW'(1);
  assign back_sum  = (IW + 1)'(front_q) + (IW + 1)'(cnt_q);
  assign back_addr = (back_sum >= (IW + 1)'(CAPACITY))
                   ? IW'(back_sum - (IW + 1)'(CAPACITY)) : IW'(back_sum);
  assign last_issue = (CW'(idx_q) == cnt_q - CW'(1));

  // request decode: update pointers and write the store at acceptance
  always_comb begin
    front_d = front_q;
    cnt_d   = cnt_q;
    stat_d  = stat_q;
    we      = 1'b0;
    waddr   = back_addr;
    if (accept) begin
      stat_d = bdws_pkg::STAT_OK;
      unique case (req_i.action)
        bdws_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            stat_d = bdws_pkg::STAT_FULL;
          end else begin
            front_d = front_dec;
            cnt_d   = cnt_q + CW'(1);
            we      = 1'b1;
            waddr   = front_dec;
          end
        end
        bdws_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            stat_d = bdws_pkg::STAT_FULL;
          end else begin
            cnt_d = cnt_q + CW'(1);
            we    = 1'b1;
          end
        end
        bdws_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            stat_d = bdws_pkg::STAT_EMPTY;
          end else begin
            front_d = front_inc;
            cnt_d   = cnt_q - CW'(1);
          end
        end
        bdws_pkg::ACT_POP_BACK: begin
          if (empty) begin
            stat_d = bdws_pkg::STAT_EMPTY;
          end else begin
            cnt_d = cnt_q - CW'(1);
          end
        end
        default: begin
          // search or unused code: state unchanged
        end
      endcase
    end
  end

  // sequencer: walk the live elements, then post the response
  always_comb begin
    state_d  = state_q;
    rd_ptr_d = rd_ptr_q;
    idx_d    = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_ptr_d = front_d;
          idx_d    = '0;
          state_d  = (cnt_d == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        rd_ptr_d = (rd_ptr_q == IW'(CAPACITY - 1)) ? '0 : rd_ptr_q + IW'(1);
        idx_d    = idx_q + IW'(1);
        if (last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      cnt_q    <= '0;
      rd_ptr_q <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      stat_q   <= bdws_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      cnt_q    <= cnt_d;
      rd_ptr_q <= rd_ptr_d;
      idx_q    <= idx_d;
      rd_vld_q <= (state_q == S_SCAN);
      stat_q   <= stat_d;
    end
  end

  // ring store
  bdws_ring #(
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // shared compare unit
  assign scan_ctrl.start     = accept;
  assign scan_ctrl.search_en = (req_i.action == bdws_pkg::ACT_SEARCH);
  assign scan_ctrl.dvalid    = rd_vld_q;

  bdws_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .key_i   (req_i.value),
    .data_i  (rdata),
    .max_o   (scan_max),
    .found_o (scan_found)
  );

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (state_q == S_DONE && rsp_free) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && rsp_free) begin
      rsp_stat_q  <= stat_q;
      rsp_found_q <= scan_found;
      rsp_cnt_q   <= cnt_q;
      rsp_max_q   <= scan_max;
    end
  end

  assign rsp_o.valid     = rsp_vld_q;
  assign rsp_o.status    = rsp_stat_q;
  assign rsp_o.found     = rsp_found_q;
  assign rsp_o.count     = rsp_cnt_q;
  assign rsp_o.max_value = rsp_max_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_full_push_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (req_i.action == bdws_pkg::ACT_PUSH_FRONT ||
                       req_i.action == bdws_pkg::ACT_PUSH_BACK)
    |=> cnt_q == $past(cnt_q) && stat_q == bdws_pkg::STAT_FULL)
    else $error("push on full queue changed the count");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !empty && (req_i.action == bdws_pkg::ACT_POP_FRONT ||
                         req_i.action == bdws_pkg::ACT_POP_BACK)
    |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("removal did not decrement the count");

  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && rsp_cnt_q == '0 |-> rsp_max_q == '0 && !rsp_found_q)
    else $error("empty queue reported a maximum or a hit");

  a_rd_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_SCAN || state_q == S_DRAIN)
    else $error("read data outside the scan window");
`endif

endmodule

`default_nettype wire
